[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// overlapping implication, disabled in reset
`define AMB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled in reset
`define AMB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[hw/rtl/amb_pkg.sv]
// ----------------------------------------------------------------------------
// amb_pkg
// Shared types, constants and address decode of the main bus decoder.
// ----------------------------------------------------------------------------
`default_nettype none
package amb_pkg;

    localparam int DataW          = 16;
    localparam int AddrW          = 24;
    localparam int WramDepth      = 8192;
    localparam int TextDepth      = 2048;
    localparam int VramDepth      = 4096;
    localparam int PaletteColors  = 4096;
    localparam int ClrW           = $clog2(WramDepth);

    localparam logic [1:0] MODE_WORD_RD = 2'd0;
    localparam logic [1:0] MODE_WORD_WR = 2'd1;
    localparam logic [1:0] MODE_BYTE_RD = 2'd2;
    localparam logic [1:0] MODE_BYTE_WR = 2'd3;

    typedef enum logic [3:0] {
        REG_NONE, REG_ROM, REG_WRAM, REG_TEXT, REG_FORE, REG_BACK, REG_SPR,
        REG_PAL, REG_SYS, REG_PLY, REG_DIP, REG_LATCH, REG_ACK, REG_FLIP
    } t_region;

    typedef struct packed {
        logic clear;
        logic load;
        logic exec;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic out_free;
    } t_sts;

    function automatic t_region decode(input logic [AddrW-1:0] a);
        t_region     r;
        logic [22:0] w;
        w = a[23:1];
        if (a <= 24'h03FFFF)          r = REG_ROM;
        else if (a[23:14] == 10'h018) r = REG_WRAM;
        else if (a[23:12] == 12'h070) r = REG_TEXT;
        else if (a[23:13] == 11'h039) r = REG_FORE;
        else if (a[23:13] == 11'h03A) r = REG_BACK;
        else if (a[23:13] == 11'h03B) r = REG_SPR;
        else if (a[23:13] == 11'h03C) r = REG_PAL;
        else if (w == 23'h03D000)     r = REG_SYS;
        else if (w == 23'h03D001)     r = REG_PLY;
        else if (w == 23'h03D002)     r = REG_DIP;
        else if (w == 23'h03D401)     r = REG_LATCH;
        else if (w == 23'h03D403)     r = REG_ACK;
        else if (w == 23'h03D404)     r = REG_FLIP;
        else                          r = REG_NONE;
        return r;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/amb_ram.sv]
// ----------------------------------------------------------------------------
// amb_ram
// Single-port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module amb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule
`default_nettype wire

[hw/rtl/amb_ctrl.sv]
// ----------------------------------------------------------------------------
// amb_ctrl
// Sequencer: RAM clearing pass, then one bus access per load/exec pair.
// ----------------------------------------------------------------------------
`default_nettype none
module amb_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire amb_pkg::t_sts i_sts,
    output logic               o_stall,
    output amb_pkg::t_cmd      o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EXEC  = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   w_accept;

    assign o_stall  = !((r_state == S_IDLE) && i_sts.out_free);
    assign w_accept = i_valid && !o_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (i_sts.clr_done) n_state = S_IDLE;
            S_IDLE:  if (w_accept) n_state = S_EXEC;
            S_EXEC:  n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd.clear = (r_state == S_CLEAR);
    assign o_cmd.load  = w_accept;
    assign o_cmd.exec  = (r_state == S_EXEC);

endmodule
`default_nettype wire

[hw/rtl/amb_datapath.sv]
// ----------------------------------------------------------------------------
// amb_datapath
// Address decode, RAM banks, read-modify-write merge and result register.
// ----------------------------------------------------------------------------
`default_nettype none
module amb_datapath #(
    parameter int PALETTE_COLORS = amb_pkg::PaletteColors
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire amb_pkg::t_cmd i_cmd,
    output amb_pkg::t_sts      o_sts,
    input  wire logic [15:0]   i_dip,
    input  wire logic [1:0]    i_mode,
    input  wire logic [23:0]   i_address,
    input  wire logic [15:0]   i_write_data,
    input  wire logic [15:0]   i_rom_word,
    input  wire logic [7:0]    i_system_buttons,
    input  wire logic [15:0]   i_player_buttons,
    input  wire logic          i_stall,
    output logic               o_valid,
    output logic [15:0]        o_read_data,
    output logic               o_latch_strobe,
    output logic [7:0]         o_latch_value,
    output logic               o_irq_ack,
    output logic               o_screen_flip,
    output logic               o_color_valid,
    output logic [11:0]        o_color_index,
    output logic [23:0]        o_color_rgb
);

    localparam int ClrW = amb_pkg::ClrW;

    logic [ClrW-1:0] r_clr_cnt;
    logic [1:0]      r_mode;
    logic [23:0]     r_address;
    logic [15:0]     r_write_data, r_rom_word, r_player_buttons;
    logic [7:0]      r_system_buttons;
    logic            r_flip;

    logic [23:0]     w_src;
    amb_pkg::t_region w_reg;
    logic [15:0]     w_wram_q, w_text_q, w_fore_q, w_back_q, w_spr_q, w_pal_q;
    logic [15:0]     w_word, w_new, w_wdata, w_rd;
    logic            w_wr, w_byte, w_pal_chg;
    logic            w_we_wram, w_we_text, w_we_fore, w_we_back, w_we_spr, w_we_pal;

    assign o_sts.clr_done = (r_clr_cnt == {ClrW{1'b1}});
    assign o_sts.out_free = !o_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clear) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode           <= i_mode;
            r_address        <= i_address;
            r_write_data     <= i_write_data;
            r_rom_word       <= i_rom_word;
            r_system_buttons <= i_system_buttons;
            r_player_buttons <= i_player_buttons;
        end
    end

    assign w_src = i_cmd.load ? i_address : r_address;
    assign w_reg = amb_pkg::decode(r_address);
    assign w_wr  = (r_mode == amb_pkg::MODE_WORD_WR) || (r_mode == amb_pkg::MODE_BYTE_WR);
    assign w_byte = (r_mode == amb_pkg::MODE_BYTE_RD) || (r_mode == amb_pkg::MODE_BYTE_WR);

    always_comb begin
        unique case (w_reg)
            amb_pkg::REG_ROM:  w_word = r_rom_word;
            amb_pkg::REG_WRAM: w_word = w_wram_q;
            amb_pkg::REG_TEXT: w_word = w_text_q;
            amb_pkg::REG_FORE: w_word = w_fore_q;
            amb_pkg::REG_BACK: w_word = w_back_q;
            amb_pkg::REG_SPR:  w_word = w_spr_q;
            amb_pkg::REG_PAL:  w_word = w_pal_q;
            amb_pkg::REG_SYS:  w_word = {8'h00, r_system_buttons};
            amb_pkg::REG_PLY:  w_word = r_player_buttons;
            amb_pkg::REG_DIP:  w_word = i_dip;
            default:           w_word = '0;
        endcase
    end

    always_comb begin
        if (!w_byte) begin
            w_new = r_write_data;
        end else if (r_address[0]) begin
            w_new = {w_word[15:8], r_write_data[7:0]};
        end else begin
            w_new = {r_write_data[7:0], w_word[7:0]};
        end
    end

    always_comb begin
        if (w_byte) begin
            w_rd = r_address[0] ? {8'h00, w_word[7:0]} : {8'h00, w_word[15:8]};
        end else begin
            w_rd = w_word;
        end
    end

    assign w_wdata   = i_cmd.clear ? '0 : w_new;
    assign w_we_wram = i_cmd.clear || (i_cmd.exec && w_wr && (w_reg == amb_pkg::REG_WRAM));
    assign w_we_text = i_cmd.clear || (i_cmd.exec && w_wr && (w_reg == amb_pkg::REG_TEXT));
    assign w_we_fore = i_cmd.clear || (i_cmd.exec && w_wr && (w_reg == amb_pkg::REG_FORE));
    assign w_we_back = i_cmd.clear || (i_cmd.exec && w_wr && (w_reg == amb_pkg::REG_BACK));
    assign w_we_spr  = i_cmd.clear || (i_cmd.exec && w_wr && (w_reg == amb_pkg::REG_SPR));
    assign w_we_pal  = i_cmd.clear || (i_cmd.exec && w_wr && (w_reg == amb_pkg::REG_PAL));

    assign w_pal_chg = w_wr && (w_reg == amb_pkg::REG_PAL) && (w_pal_q != w_new)
                       && ({1'b0, r_address[12:1]} < 13'(PALETTE_COLORS));

    amb_ram #(.WIDTH(16), .DEPTH(amb_pkg::WramDepth)) u_wram (
        .i_clk(i_clk), .i_we(w_we_wram),
        .i_addr(i_cmd.clear ? r_clr_cnt : w_src[13:1]),
        .i_wdata(w_wdata), .o_rdata(w_wram_q));

    amb_ram #(.WIDTH(16), .DEPTH(amb_pkg::TextDepth)) u_text (
        .i_clk(i_clk), .i_we(w_we_text),
        .i_addr(i_cmd.clear ? r_clr_cnt[10:0] : w_src[11:1]),
        .i_wdata(w_wdata), .o_rdata(w_text_q));

    amb_ram #(.WIDTH(16), .DEPTH(amb_pkg::VramDepth)) u_fore (
        .i_clk(i_clk), .i_we(w_we_fore),
        .i_addr(i_cmd.clear ? r_clr_cnt[11:0] : w_src[12:1]),
        .i_wdata(w_wdata), .o_rdata(w_fore_q));

    amb_ram #(.WIDTH(16), .DEPTH(amb_pkg::VramDepth)) u_back (
        .i_clk(i_clk), .i_we(w_we_back),
        .i_addr(i_cmd.clear ? r_clr_cnt[11:0] : w_src[12:1]),
        .i_wdata(w_wdata), .o_rdata(w_back_q));

    amb_ram #(.WIDTH(16), .DEPTH(amb_pkg::VramDepth)) u_spr (
        .i_clk(i_clk), .i_we(w_we_spr),
        .i_addr(i_cmd.clear ? r_clr_cnt[11:0] : w_src[12:1]),
        .i_wdata(w_wdata), .o_rdata(w_spr_q));

    amb_ram #(.WIDTH(16), .DEPTH(amb_pkg::VramDepth)) u_pal (
        .i_clk(i_clk), .i_we(w_we_pal),
        .i_addr(i_cmd.clear ? r_clr_cnt[11:0] : w_src[12:1]),
        .i_wdata(w_wdata), .o_rdata(w_pal_q));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flip  <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                o_valid <= 1'b1;
                if (w_wr && (w_reg == amb_pkg::REG_FLIP)) begin
                    r_flip <= w_new[0];
                end
            end else if (!i_stall) begin
                o_valid <= 1'b0;
            end
        end
    end

    // result payload, loaded once per transfer
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            o_read_data    <= w_wr ? '0 : w_rd;
            o_latch_strobe <= w_wr && (w_reg == amb_pkg::REG_LATCH);
            o_latch_value  <= (w_wr && (w_reg == amb_pkg::REG_LATCH)) ? w_new[7:0] : '0;
            o_irq_ack      <= w_wr && (w_reg == amb_pkg::REG_ACK);
            o_screen_flip  <= (w_wr && (w_reg == amb_pkg::REG_FLIP)) ? w_new[0] : r_flip;
            o_color_valid  <= w_pal_chg;
            o_color_index  <= w_pal_chg ? r_address[12:1] : '0;
            o_color_rgb    <= w_pal_chg ? {w_new[3:0], w_new[3:0], w_new[7:4], w_new[7:4],
                                           w_new[11:8], w_new[11:8]} : '0;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/arcade_main_bus_decoder.sv]
// ----------------------------------------------------------------------------
// arcade_main_bus_decoder
// 68000-style main bus decoder: memories, ports, latch and palette output.
// ----------------------------------------------------------------------------
// Result path: RAM read at the input transfer, then merge/write and result load
// in the exec state; no new access is taken during it (read-then-write RAM).
// Reset: synchronous; after reset all RAMs are cleared, during which no input is
// taken. DIP switch register resets to 0xFFFF.
`default_nettype none
`include "assert_macros.svh"
module arcade_main_bus_decoder #(
    parameter int PALETTE_COLORS = amb_pkg::PaletteColors
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_mode,
    input  wire logic [23:0] i_address,
    input  wire logic [15:0] i_write_data,
    input  wire logic [15:0] i_rom_word,
    input  wire logic [7:0]  i_system_buttons,
    input  wire logic [15:0] i_player_buttons,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [15:0]      o_read_data,
    output logic             o_latch_strobe,
    output logic [7:0]       o_latch_value,
    output logic             o_irq_ack,
    output logic             o_screen_flip,
    output logic             o_color_valid,
    output logic [11:0]      o_color_index,
    output logic [23:0]      o_color_rgb
);

    logic [15:0]   r_dip;
    amb_pkg::t_cmd w_cmd;
    amb_pkg::t_sts w_sts;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {16'h0000, r_dip} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dip <= 16'hFFFF;
        end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
            r_dip <= pwdata[15:0];
        end
    end

    amb_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid),
        .i_sts(w_sts), .o_stall(o_stall), .o_cmd(w_cmd));

    amb_datapath #(.PALETTE_COLORS(PALETTE_COLORS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_sts(w_sts), .i_dip(r_dip),
        .i_mode(i_mode), .i_address(i_address), .i_write_data(i_write_data),
        .i_rom_word(i_rom_word), .i_system_buttons(i_system_buttons),
        .i_player_buttons(i_player_buttons), .i_stall(i_stall), .o_valid(o_valid),
        .o_read_data(o_read_data), .o_latch_strobe(o_latch_strobe),
        .o_latch_value(o_latch_value), .o_irq_ack(o_irq_ack),
        .o_screen_flip(o_screen_flip), .o_color_valid(o_color_valid),
        .o_color_index(o_color_index), .o_color_rgb(o_color_rgb));

    `AMB_ASSERT_NXT(a_load_exec, i_clk, i_rst_n, i_valid && !o_stall, w_cmd.exec)
    `AMB_ASSERT_NXT(a_exec_out, i_clk, i_rst_n, w_cmd.exec, o_valid)
    `AMB_ASSERT_IMP(a_clear_stall, i_clk, i_rst_n, w_cmd.clear, o_stall)
    `AMB_ASSERT_IMP(a_color_wr, i_clk, i_rst_n, o_valid && o_color_valid, o_read_data == 16'h0000)

endmodule
`default_nettype wire

[sim/arcade_main_bus_decoder_test.sv]
// ----------------------------------------------------------------------------
// arcade_main_bus_decoder_test
// Self-checking bench: directed table then random bus accesses, each result
// compared with a behavioral copy of the memory map, RAMs and registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module arcade_main_bus_decoder_test;

    typedef struct {
        logic [1:0]  mode;
        logic [23:0] addr;
        logic [15:0] wdata;
        logic [15:0] rom;
        logic [7:0]  sys;
        logic [15:0] ply;
        logic        has_rd;
        logic [15:0] rd;
    } t_access;

    typedef struct {
        logic [15:0] rd;
        logic        strobe;
        logic [7:0]  latch;
        logic        ack;
        logic        flip;
        logic        cvalid;
        logic [11:0] cindex;
        logic [23:0] rgb;
        logic        chk_rd_only;
        logic [15:0] fixed_rd;
    } t_bus_result;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [2:0]  paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid = 0;
    logic        o_stall;
    logic [1:0]  i_mode = 0;
    logic [23:0] i_address = 0;
    logic [15:0] i_write_data = 0, i_rom_word = 0, i_player_buttons = 0;
    logic [7:0]  i_system_buttons = 0;
    logic        o_valid;
    logic        i_stall = 0;
    logic [15:0] o_read_data;
    logic        o_latch_strobe, o_irq_ack, o_screen_flip, o_color_valid;
    logic [7:0]  o_latch_value;
    logic [11:0] o_color_index;
    logic [23:0] o_color_rgb;

    arcade_main_bus_decoder uut (.*);

    always begin
        #6 i_clk = 1;
        #6 i_clk = 0;
    end

    logic [15:0] wram_m [8192];
    logic [15:0] text_m [2048];
    logic [15:0] fore_m [4096];
    logic [15:0] back_m [4096];
    logic [15:0] spr_m  [4096];
    logic [15:0] pal_m  [4096];
    logic [15:0] scroll_m [6];
    logic [7:0]  offs_m [3];
    logic        flip_m;
    logic [15:0] dip_m;

    t_bus_result pending_results[$];
    int          errors = 0;
    bit          hold_long = 0;
    bit          stim_done = 0;

    function automatic logic [15:0] map_read(logic [23:0] a, logic [15:0] rom,
                                             logic [7:0] sys, logic [15:0] ply);
        case (amb_pkg::decode(a))
            amb_pkg::REG_ROM:  return rom;
            amb_pkg::REG_WRAM: return wram_m[a[13:1]];
            amb_pkg::REG_TEXT: return text_m[a[11:1]];
            amb_pkg::REG_FORE: return fore_m[a[12:1]];
            amb_pkg::REG_BACK: return back_m[a[12:1]];
            amb_pkg::REG_SPR:  return spr_m[a[12:1]];
            amb_pkg::REG_PAL:  return pal_m[a[12:1]];
            amb_pkg::REG_SYS:  return {8'h00, sys};
            amb_pkg::REG_PLY:  return ply;
            amb_pkg::REG_DIP:  return dip_m;
            default:           return 16'h0000;
        endcase
    endfunction

    function automatic void map_write(logic [23:0] a, logic [15:0] v,
                                      inout t_bus_result r);
        logic [23:0] w;
        logic [3:0]  layer;
        logic [11:0] idx;
        w = {a[23:1], 1'b0};
        case (amb_pkg::decode(a))
            amb_pkg::REG_WRAM: wram_m[a[13:1]] = v;
            amb_pkg::REG_TEXT: text_m[a[11:1]] = v;
            amb_pkg::REG_FORE: fore_m[a[12:1]] = v;
            amb_pkg::REG_BACK: back_m[a[12:1]] = v;
            amb_pkg::REG_SPR:  spr_m[a[12:1]] = v;
            amb_pkg::REG_PAL: begin
                idx = a[12:1];
                if (pal_m[idx] != v) begin
                    pal_m[idx] = v;
                    r.cvalid = 1'b1;
                    r.cindex = idx;
                    r.rgb = {v[3:0] * 8'h11, v[7:4] * 8'h11, v[11:8] * 8'h11};
                end
            end
            amb_pkg::REG_LATCH: begin
                r.strobe = 1'b1;
                r.latch = v[7:0];
            end
            amb_pkg::REG_ACK:  r.ack = 1'b1;
            amb_pkg::REG_FLIP: flip_m = v[0];
            default: begin
                if (w >= 24'h07A100 && w <= 24'h07A3FF) begin
                    layer = w[11:8] - 4'd1;
                    if (layer < 4'd3) begin
                        if (w[7:0] == 8'h04) scroll_m[layer * 2] = v;
                        else if (w[7:0] == 8'h08) offs_m[layer] = v[7:0];
                        else if (w[7:0] == 8'h0C) scroll_m[layer * 2 + 1] = v;
                    end
                end
            end
        endcase
    endfunction

    function automatic t_bus_result predict_access(t_access x);
        t_bus_result r;
        logic [15:0] wv;
        r = '{default: 0};
        case (x.mode)
            amb_pkg::MODE_WORD_RD: r.rd = map_read(x.addr, x.rom, x.sys, x.ply);
            amb_pkg::MODE_WORD_WR: map_write(x.addr, x.wdata, r);
            amb_pkg::MODE_BYTE_RD: begin
                wv = map_read(x.addr, x.rom, x.sys, x.ply);
                r.rd = x.addr[0] ? {8'h00, wv[7:0]} : {8'h00, wv[15:8]};
            end
            default: begin
                wv = map_read(x.addr, x.rom, x.sys, x.ply);
                if (x.addr[0]) wv[7:0] = x.wdata[7:0];
                else wv[15:8] = x.wdata[7:0];
                map_write(x.addr, wv, r);
            end
        endcase
        r.flip = flip_m;
        r.chk_rd_only = x.has_rd;
        r.fixed_rd = x.rd;
        return r;
    endfunction

    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) < 6) ? 0 :
            (($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 30));
        if (n != 0) i_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic send_access(t_access x);
        pending_results = {pending_results, predict_access(x)};
        i_valid <= 1;
        i_mode <= x.mode;
        i_address <= x.addr;
        i_write_data <= x.wdata;
        i_rom_word <= x.rom;
        i_system_buttons <= x.sys;
        i_player_buttons <= x.ply;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        idle_gap();
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic set_dip(logic [15:0] v);
        psel <= 1;
        pwrite <= 1;
        paddr <= 3'd0;
        pwdata <= {16'h0000, v};
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        dip_m = v;
        @(posedge i_clk);
    endtask

    function automatic logic [23:0] pick_addr();
        logic [23:0] a;
        case ($urandom_range(0, 15))
            0:  a = 24'($urandom_range(0, 24'h03FFFF));
            1, 2: a = 24'h060000 + 24'($urandom_range(0, 63));
            3:  a = 24'h070000 + 24'($urandom_range(0, 63));
            4:  a = 24'h072000 + 24'($urandom_range(0, 63));
            5:  a = 24'h074000 + 24'($urandom_range(0, 63));
            6:  a = 24'h076000 + 24'($urandom_range(0, 63));
            7, 8: a = 24'h078000 + 24'($urandom_range(0, 31));
            9:  a = 24'h078000 + 24'($urandom_range(0, 24'h1FFF));
            10: a = 24'h07A000 + 24'($urandom_range(0, 7));
            11: a = 24'h07A100 + 24'($urandom_range(1, 3) << 8) + 24'($urandom_range(0, 15));
            12: a = 24'h07A800 + 24'($urandom_range(0, 11));
            13: a = 24'($urandom_range(0, 24'hFFFFFF));
            default: a = 24'h060000 + 24'($urandom_range(0, 24'h3FFF));
        endcase
        return a;
    endfunction

    t_access directed_rows[] = '{
        '{amb_pkg::MODE_WORD_RD, 24'h000000, 16'h0000, 16'hFFFF, 8'h00, 16'h0000, 1'b1, 16'hFFFF},
        '{amb_pkg::MODE_WORD_RD, 24'h07A004, 16'h0000, 16'h0000, 8'h00, 16'h0000, 1'b1, 16'hFFFF},
        '{amb_pkg::MODE_WORD_RD, 24'h07A000, 16'h0000, 16'h0000, 8'hA5, 16'h0000, 1'b1, 16'h00A5},
        '{amb_pkg::MODE_BYTE_RD, 24'h07A002, 16'h0000, 16'h0000, 8'h00, 16'hC33C, 1'b1, 16'h00C3},
        '{amb_pkg::MODE_BYTE_RD, 24'h07A003, 16'h0000, 16'h0000, 8'h00, 16'hC33C, 1'b1, 16'h003C},
        '{amb_pkg::MODE_WORD_RD, 24'hFFFFFF, 16'h0000, 16'hFFFF, 8'hFF, 16'hFFFF, 1'b1, 16'h0000},
        '{amb_pkg::MODE_WORD_RD, 24'h063FFE, 16'h0000, 16'h0000, 8'h00, 16'h0000, 1'b1, 16'h0000},
        '{amb_pkg::MODE_WORD_WR, 24'h03FFFE, 16'h1234, 16'h0000, 8'h00, 16'h0000, 1'b1, 16'h0000},
        '{amb_pkg::MODE_WORD_WR, 24'h060000, 16'hFFFF, 16'h0000, 8'h00, 16'h0000, 1'b0, 16'h0000},
        '{amb_pkg::MODE_BYTE_WR, 24'h060001, 16'hAB12, 16'h0000, 8'h00, 16'h0000, 1'b0, 16'h0000},
        '{amb_pkg::MODE_WORD_RD, 24'h060000, 16'h0000, 16'h0000, 8'h00, 16'h0000, 1'b1, 16'hFF12},
        '{amb_pkg::MODE_WORD_WR, 24'h063FFE, 16'hBEEF, 16'h0000, 8'h00, 16'h0000, 1'b0, 16'h0000},
        '{amb_pkg::MODE_WORD_WR, 24'h078000, 16'h0FFF, 16'h0000, 8'h00, 16'h0000, 1'b0, 16'h0000},
        '{amb_pkg::MODE_WORD_WR, 24'h078000, 16'h0FFF, 16'h0000, 8'h00, 16'h0000, 1'b0, 16'h0000},
        '{amb_pkg::MODE_BYTE_WR, 24'h079FFE, 16'h0012, 16'h0000, 8'h00, 16'h0000, 1'b0, 16'h0000},
        '{amb_pkg::MODE_WORD_WR, 24'h07A802, 16'hFF5A, 16'h0000, 8'h00, 16'h0000, 1'b0, 16'h0000},
        '{amb_pkg::MODE_BYTE_WR, 24'h07A802, 16'h0077, 16'h0000, 8'h00, 16'h0000, 1'b0, 16'h0000},
        '{amb_pkg::MODE_BYTE_WR, 24'h07A803, 16'h0077, 16'h0000, 8'h00, 16'h0000, 1'b0, 16'h0000},
        '{amb_pkg::MODE_WORD_WR, 24'h07A806, 16'h0000, 16'h0000, 8'h00, 16'h0000, 1'b0, 16'h0000},
        '{amb_pkg::MODE_WORD_WR, 24'h07A808, 16'hFFFF, 16'h0000, 8'h00, 16'h0000, 1'b0, 16'h0000},
        '{amb_pkg::MODE_BYTE_WR, 24'h07A808, 16'h0001, 16'h0000, 8'h00, 16'h0000, 1'b0, 16'h0000},
        '{amb_pkg::MODE_WORD_WR, 24'h07A30C, 16'h5555, 16'h0000, 8'h00, 16'h0000, 1'b0, 16'h0000},
        '{amb_pkg::MODE_WORD_WR, 24'h07A208, 16'hAAAA, 16'h0000, 8'h00, 16'h0000, 1'b0, 16'h0000},
        '{amb_pkg::MODE_WORD_WR, 24'h07A800, 16'h1111, 16'h0000, 8'h00, 16'h0000, 1'b0, 16'h0000}
    };

    // Result side: random stall, one long hold-off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_long) begin
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 9) < 3) ? ($urandom_range(0, 9) != 0) : 1'b0;
        end
    end

    initial begin
        @(posedge i_clk);
        wait (stim_done == 0 && i_rst_n);
        forever begin
            repeat (2000) @(posedge i_clk);
            if (stim_done) break;
        end
    end

    always @(posedge i_clk) begin
        t_bus_result e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result transfer");
                errors++;
            end else begin
                e = pending_results.pop_front();
                if (e.chk_rd_only && o_read_data !== e.fixed_rd) begin
                    $error("read_data (table) exp %h got %h", e.fixed_rd, o_read_data);
                    errors++;
                end
                if (o_read_data !== e.rd) begin
                    $error("read_data exp %h got %h", e.rd, o_read_data); errors++;
                end
                if (o_latch_strobe !== e.strobe) begin
                    $error("latch_strobe exp %h got %h", e.strobe, o_latch_strobe); errors++;
                end
                if (o_latch_value !== e.latch) begin
                    $error("latch_value exp %h got %h", e.latch, o_latch_value); errors++;
                end
                if (o_irq_ack !== e.ack) begin
                    $error("irq_ack exp %h got %h", e.ack, o_irq_ack); errors++;
                end
                if (o_screen_flip !== e.flip) begin
                    $error("screen_flip exp %h got %h", e.flip, o_screen_flip); errors++;
                end
                if (o_color_valid !== e.cvalid) begin
                    $error("color_valid exp %h got %h", e.cvalid, o_color_valid); errors++;
                end
                if (o_color_index !== e.cindex) begin
                    $error("color_index exp %h got %h", e.cindex, o_color_index); errors++;
                end
                if (o_color_rgb !== e.rgb) begin
                    $error("color_rgb exp %h got %h", e.rgb, o_color_rgb); errors++;
                end
            end
        end
    end

    initial begin
        t_access x;
        int k;
        foreach (wram_m[j]) wram_m[j] = 0;
        foreach (text_m[j]) text_m[j] = 0;
        foreach (fore_m[j]) fore_m[j] = 0;
        foreach (back_m[j]) back_m[j] = 0;
        foreach (spr_m[j]) spr_m[j] = 0;
        foreach (pal_m[j]) pal_m[j] = 0;
        foreach (scroll_m[j]) scroll_m[j] = 0;
        foreach (offs_m[j]) offs_m[j] = 0;
        flip_m = 0;
        dip_m = 16'hFFFF;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        foreach (directed_rows[j]) send_access(directed_rows[j]);
        drain();

        for (k = 0; k < 550; k++) begin
            if (k % 110 == 0) begin
                drain();
                case (k / 110)
                    0: set_dip(16'h0000);
                    1: set_dip(16'hFFFF);
                    default: set_dip(16'($urandom_range(0, 16'hFFFF)));
                endcase
            end
            if (k == 200) begin
                fork
                    begin
                        hold_long = 1'b1;
                        repeat (60) @(posedge i_clk);
                        hold_long = 1'b0;
                    end
                join_none
            end
            if (k == 300) drain();
            x.mode = 2'($urandom_range(0, 3));
            x.addr = pick_addr();
            x.wdata = 16'($urandom_range(0, 16'hFFFF));
            x.rom = 16'($urandom_range(0, 16'hFFFF));
            x.sys = 8'($urandom_range(0, 8'hFF));
            x.ply = 16'($urandom_range(0, 16'hFFFF));
            x.has_rd = 1'b0;
            x.rd = '0;
            send_access(x);
        end
        drain();
        stim_done = 1'b1;
        if (errors == 0) begin
            $display("arcade_main_bus_decoder_test: clean");
        end else begin
            $display("arcade_main_bus_decoder_test: errors");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("arcade_main_bus_decoder_test: errors");
        $finish;
    end
endmodule
